### hw/rtl/idll_pkg.sv
// shared types and constants of the indexed doubly linked list
`default_nettype none

package idll_pkg;

  // active slot register
  localparam int unsigned ACT_W = 9;
  localparam logic [ACT_W-1:0] ACT_RESET = 9'd256;

  // request modes
  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_MOVE_BACK  = 3'd4,
    MODE_MOVE_FRONT = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_EMPTY   = 2'd2
  } status_t;

  // request and result payloads
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] target_slot;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot;
    logic [7:0] front_slot;
    logic [7:0] back_slot;
    logic       list_empty;
    logic       pool_full;
  } out_rsp_t;

  // operand sources for link addresses, link data and index registers
  typedef enum logic [2:0] {
    LS_NIL,
    LS_IDX,
    LS_P,
    LS_Q,
    LS_BACK,
    LS_FRONT,
    LS_FREE
  } link_sel_t;

  // source of the working slot index
  typedef enum logic [1:0] {
    IS_FREE,
    IS_BACK,
    IS_FRONT,
    IS_TARGET
  } idx_sel_t;

  // source of the result slot field
  typedef enum logic [1:0] {
    SS_ZERO,
    SS_IDX,
    SS_TARGET
  } slot_sel_t;

  typedef struct packed {
    logic      en;
    link_sel_t addr;
    link_sel_t data;
  } wr_cmd_t;

  typedef struct packed {
    logic      en;
    link_sel_t src;
  } reg_cmd_t;

  // controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      rd_en;
    idx_sel_t  idx_src;
    logic      clr_init;
    logic      sweep;
    wr_cmd_t   prev_wr;
    wr_cmd_t   next_wr;
    reg_cmd_t  front_upd;
    reg_cmd_t  back_upd;
    reg_cmd_t  free_upd;
    logic      out_load;
    status_t   out_status;
    slot_sel_t out_slot;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] mode;
    logic       free_nil;
    logic       front_nil;
    logic       back_nil;
    logic       p_nil;
    logic       q_nil;
    logic       tgt_oor;
    logic       sweep_done;
    logic       out_hold;
  } dp_stat_t;

  // controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/idll_ram.sv
// generic single write port ram with registered read
`default_nettype none

module idll_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and held read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/idll_ctrl.sv
// command sequencer of the indexed doubly linked list
`default_nettype none

module idll_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  idll_pkg::dp_stat_t  stat,
  output idll_pkg::dp_cmd_t   cmd
);

  idll_pkg::state_t    state_r, state_nxt;
  idll_pkg::status_t   status_r, status_nxt;
  idll_pkg::slot_sel_t slot_r, slot_nxt;

  function automatic idll_pkg::wr_cmd_t wr(input idll_pkg::link_sel_t a,
                                           input idll_pkg::link_sel_t d);
    wr = '{1'b1, a, d};
  endfunction

  function automatic idll_pkg::reg_cmd_t upd(input idll_pkg::link_sel_t s);
    upd = '{1'b1, s};
  endfunction

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= idll_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result status held until the result is loaded
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    slot_nxt       = slot_r;
    cmd            = '0;
    cmd.out_status = status_r;
    cmd.out_slot   = slot_r;
    in_ready       = 1'b0;
    unique case (state_r)
      idll_pkg::ST_INIT: begin
        if (stat.sweep_done) begin
          state_nxt = idll_pkg::ST_IDLE;
        end else begin
          cmd.sweep = 1'b1;
        end
      end
      idll_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = idll_pkg::ST_READ;
        end
      end
      // pick the working slot, check empty, full or range, read its links, or start a clear
      idll_pkg::ST_READ: begin
        status_nxt = idll_pkg::STATUS_DONE;
        slot_nxt   = idll_pkg::SS_ZERO;
        state_nxt  = idll_pkg::ST_DONE;
        unique case (stat.mode) inside
          idll_pkg::MODE_PUSH_BACK, idll_pkg::MODE_PUSH_FRONT: begin
            if (stat.free_nil) begin
              status_nxt = idll_pkg::STATUS_NO_FREE;
            end else begin
              cmd.idx_src = idll_pkg::IS_FREE;
              cmd.rd_en   = 1'b1;
              slot_nxt    = idll_pkg::SS_IDX;
              state_nxt   = idll_pkg::ST_W1;
            end
          end
          idll_pkg::MODE_POP_BACK: begin
            if (stat.front_nil || stat.back_nil) begin
              status_nxt = idll_pkg::STATUS_EMPTY;
            end else begin
              cmd.idx_src = idll_pkg::IS_BACK;
              cmd.rd_en   = 1'b1;
              slot_nxt    = idll_pkg::SS_IDX;
              state_nxt   = idll_pkg::ST_W1;
            end
          end
          idll_pkg::MODE_POP_FRONT: begin
            if (stat.front_nil) begin
              status_nxt = idll_pkg::STATUS_EMPTY;
            end else begin
              cmd.idx_src = idll_pkg::IS_FRONT;
              cmd.rd_en   = 1'b1;
              slot_nxt    = idll_pkg::SS_IDX;
              state_nxt   = idll_pkg::ST_W1;
            end
          end
          idll_pkg::MODE_MOVE_BACK, idll_pkg::MODE_MOVE_FRONT: begin
            slot_nxt = idll_pkg::SS_TARGET;
            if (!stat.tgt_oor) begin
              cmd.idx_src = idll_pkg::IS_TARGET;
              cmd.rd_en   = 1'b1;
              state_nxt   = idll_pkg::ST_W1;
            end
          end
          idll_pkg::MODE_CLEAR: begin
            cmd.clr_init = 1'b1;
            state_nxt    = idll_pkg::ST_CLEAR;
          end
          default: begin
          end
        endcase
      end
      // first link update, links of the working slot are on the ram outputs
      idll_pkg::ST_W1: begin
        state_nxt = idll_pkg::ST_DONE;
        unique case (stat.mode) inside
          idll_pkg::MODE_PUSH_BACK, idll_pkg::MODE_PUSH_FRONT: begin
            cmd.free_upd = upd(idll_pkg::LS_Q);
            if (stat.front_nil) begin
              cmd.prev_wr   = wr(idll_pkg::LS_IDX, idll_pkg::LS_NIL);
              cmd.next_wr   = wr(idll_pkg::LS_IDX, idll_pkg::LS_NIL);
              cmd.front_upd = upd(idll_pkg::LS_IDX);
              cmd.back_upd  = upd(idll_pkg::LS_IDX);
            end else if (stat.mode == idll_pkg::MODE_PUSH_BACK) begin
              cmd.next_wr = wr(idll_pkg::LS_BACK, idll_pkg::LS_IDX);
              cmd.prev_wr = wr(idll_pkg::LS_IDX, idll_pkg::LS_BACK);
              state_nxt   = idll_pkg::ST_W2;
            end else begin
              cmd.prev_wr = wr(idll_pkg::LS_FRONT, idll_pkg::LS_IDX);
              cmd.next_wr = wr(idll_pkg::LS_IDX, idll_pkg::LS_FRONT);
              state_nxt   = idll_pkg::ST_W2;
            end
          end
          idll_pkg::MODE_POP_BACK: begin
            cmd.next_wr  = wr(idll_pkg::LS_IDX, idll_pkg::LS_FREE);
            cmd.free_upd = upd(idll_pkg::LS_IDX);
            if (stat.p_nil) begin
              cmd.front_upd = upd(idll_pkg::LS_NIL);
              cmd.back_upd  = upd(idll_pkg::LS_NIL);
            end else begin
              state_nxt = idll_pkg::ST_W2;
            end
          end
          idll_pkg::MODE_POP_FRONT: begin
            cmd.next_wr  = wr(idll_pkg::LS_IDX, idll_pkg::LS_FREE);
            cmd.free_upd = upd(idll_pkg::LS_IDX);
            if (stat.q_nil) begin
              cmd.front_upd = upd(idll_pkg::LS_NIL);
              cmd.back_upd  = upd(idll_pkg::LS_NIL);
            end else begin
              cmd.prev_wr   = wr(idll_pkg::LS_Q, idll_pkg::LS_NIL);
              cmd.front_upd = upd(idll_pkg::LS_Q);
            end
          end
          idll_pkg::MODE_MOVE_BACK: begin
            // already at the back: nothing to do
            if (!stat.q_nil) begin
              cmd.prev_wr = wr(idll_pkg::LS_Q, idll_pkg::LS_P);
              cmd.next_wr = wr(idll_pkg::LS_P, idll_pkg::LS_Q);
              if (stat.p_nil) begin
                cmd.front_upd = upd(idll_pkg::LS_Q);
              end
              state_nxt = idll_pkg::ST_W2;
            end
          end
          idll_pkg::MODE_MOVE_FRONT: begin
            // already at the front: nothing to do
            if (!stat.p_nil) begin
              cmd.next_wr = wr(idll_pkg::LS_P, idll_pkg::LS_Q);
              cmd.prev_wr = wr(idll_pkg::LS_Q, idll_pkg::LS_P);
              if (stat.q_nil) begin
                cmd.back_upd = upd(idll_pkg::LS_P);
              end
              state_nxt = idll_pkg::ST_W2;
            end
          end
          default: begin
          end
        endcase
      end
      // second link update
      idll_pkg::ST_W2: begin
        state_nxt = idll_pkg::ST_DONE;
        unique case (stat.mode) inside
          idll_pkg::MODE_PUSH_BACK: begin
            cmd.next_wr  = wr(idll_pkg::LS_IDX, idll_pkg::LS_NIL);
            cmd.back_upd = upd(idll_pkg::LS_IDX);
          end
          idll_pkg::MODE_PUSH_FRONT: begin
            cmd.prev_wr   = wr(idll_pkg::LS_IDX, idll_pkg::LS_NIL);
            cmd.front_upd = upd(idll_pkg::LS_IDX);
          end
          idll_pkg::MODE_POP_BACK: begin
            cmd.next_wr  = wr(idll_pkg::LS_P, idll_pkg::LS_NIL);
            cmd.back_upd = upd(idll_pkg::LS_P);
          end
          idll_pkg::MODE_MOVE_BACK: begin
            cmd.prev_wr = wr(idll_pkg::LS_IDX, idll_pkg::LS_BACK);
            cmd.next_wr = wr(idll_pkg::LS_BACK, idll_pkg::LS_IDX);
            state_nxt   = idll_pkg::ST_W3;
          end
          idll_pkg::MODE_MOVE_FRONT: begin
            cmd.prev_wr = wr(idll_pkg::LS_FRONT, idll_pkg::LS_IDX);
            cmd.next_wr = wr(idll_pkg::LS_IDX, idll_pkg::LS_FRONT);
            state_nxt   = idll_pkg::ST_W3;
          end
          default: begin
          end
        endcase
      end
      // last link update of a move
      idll_pkg::ST_W3: begin
        state_nxt = idll_pkg::ST_DONE;
        if (stat.mode == idll_pkg::MODE_MOVE_BACK) begin
          cmd.next_wr  = wr(idll_pkg::LS_IDX, idll_pkg::LS_NIL);
          cmd.back_upd = upd(idll_pkg::LS_IDX);
        end else begin
          cmd.prev_wr   = wr(idll_pkg::LS_IDX, idll_pkg::LS_NIL);
          cmd.front_upd = upd(idll_pkg::LS_IDX);
        end
      end
      idll_pkg::ST_CLEAR: begin
        if (stat.sweep_done) begin
          state_nxt = idll_pkg::ST_DONE;
        end else begin
          cmd.sweep = 1'b1;
        end
      end
      // hand the result to the output register once it is free
      idll_pkg::ST_DONE: begin
        if (!stat.out_hold) begin
          cmd.out_load = 1'b1;
          state_nxt    = idll_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = idll_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/idll_dp.sv
// link stores, list pointers, sweep counter and result register
`default_nettype none

module idll_dp #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  idll_pkg::in_req_t              in_data,
  input  logic [idll_pkg::ACT_W-1:0]     active_slots,
  input  idll_pkg::dp_cmd_t              cmd,
  output idll_pkg::dp_stat_t             stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output idll_pkg::out_rsp_t             out_data
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned CW = (LW > idll_pkg::ACT_W) ? LW : idll_pkg::ACT_W;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);
  localparam logic [LW-1:0] INIT_N =
    (SLOTS < idll_pkg::ACT_RESET) ? LW'(SLOTS) : LW'(idll_pkg::ACT_RESET);

  logic [2:0]          mode_r;
  logic [7:0]          target_r;
  logic [LW-1:0]       idx_r;
  logic [LW-1:0]       front_r;
  logic [LW-1:0]       back_r;
  logic [LW-1:0]       free_r;
  logic [LW-1:0]       sweep_r;
  logic [LW-1:0]       sweep_lim_r;
  logic [LW-1:0]       sweep_n_r;
  logic                out_valid_r;
  idll_pkg::out_rsp_t  out_data_r;

  logic [CW-1:0]       act_ext;
  logic [CW-1:0]       count_c;
  logic [LW-1:0]       count_l;
  logic [CW-1:0]       tgt_ext;
  logic [LW-1:0]       idx_sel;
  logic [LW-1:0]       prev_rd;
  logic [LW-1:0]       next_rd;
  logic [LW-1:0]       prev_wa;
  logic [LW-1:0]       prev_wd;
  logic                prev_en;
  logic [LW-1:0]       next_wa;
  logic [LW-1:0]       next_wd;
  logic                next_en;
  logic [LW-1:0]       sweep_inc;
  logic [LW-1:0]       sweep_link;
  idll_pkg::out_rsp_t  rsp;

  function automatic logic [LW-1:0] pick(input idll_pkg::link_sel_t sel,
                                         input logic [LW-1:0] idx,
                                         input logic [LW-1:0] p,
                                         input logic [LW-1:0] q,
                                         input logic [LW-1:0] back,
                                         input logic [LW-1:0] front,
                                         input logic [LW-1:0] free);
    case (sel)
      idll_pkg::LS_IDX:   pick = idx;
      idll_pkg::LS_P:     pick = p;
      idll_pkg::LS_Q:     pick = q;
      idll_pkg::LS_BACK:  pick = back;
      idll_pkg::LS_FRONT: pick = front;
      idll_pkg::LS_FREE:  pick = free;
      default:            pick = NIL;
    endcase
  endfunction

  function automatic logic [7:0] low8(input logic [LW-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    return e[7:0];
  endfunction

  // active count clamped to the pool size, move range check
  assign act_ext = CW'(active_slots);
  assign count_c = (act_ext > CW'(SLOTS)) ? CW'(SLOTS) : act_ext;
  assign count_l = count_c[LW-1:0];
  assign tgt_ext = CW'(target_r);

  // working slot select
  always_comb begin
    case (cmd.idx_src)
      idll_pkg::IS_FREE:  idx_sel = free_r;
      idll_pkg::IS_BACK:  idx_sel = back_r;
      idll_pkg::IS_FRONT: idx_sel = front_r;
      default:            idx_sel = tgt_ext[LW-1:0];
    endcase
  end

  // sweep link: next active slot or null past the end
  assign sweep_inc  = sweep_r + LW'(1);
  assign sweep_link = (sweep_inc < sweep_n_r) ? sweep_inc : NIL;

  // link writes, a null address is skipped
  always_comb begin
    prev_wa = pick(cmd.prev_wr.addr, idx_r, prev_rd, next_rd, back_r, front_r, free_r);
    prev_wd = pick(cmd.prev_wr.data, idx_r, prev_rd, next_rd, back_r, front_r, free_r);
    prev_en = cmd.prev_wr.en && (prev_wa != NIL);
    next_wa = pick(cmd.next_wr.addr, idx_r, prev_rd, next_rd, back_r, front_r, free_r);
    next_wd = pick(cmd.next_wr.data, idx_r, prev_rd, next_rd, back_r, front_r, free_r);
    next_en = cmd.next_wr.en && (next_wa != NIL);
    if (cmd.sweep) begin
      prev_wa = sweep_r;
      prev_wd = NIL;
      prev_en = 1'b1;
      next_wa = sweep_r;
      next_wd = sweep_link;
      next_en = 1'b1;
    end
  end

  idll_ram #(
    .WIDTH (LW),
    .DEPTH (SLOTS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prev_en),
    .waddr (prev_wa[IW-1:0]),
    .wdata (prev_wd),
    .re    (cmd.rd_en),
    .raddr (idx_sel[IW-1:0]),
    .rdata (prev_rd)
  );

  idll_ram #(
    .WIDTH (LW),
    .DEPTH (SLOTS)
  ) u_next_ram (
    .clk   (clk),
    .we    (next_en),
    .waddr (next_wa[IW-1:0]),
    .wdata (next_wd),
    .re    (cmd.rd_en),
    .raddr (idx_sel[IW-1:0]),
    .rdata (next_rd)
  );

  // list pointers, free head, sweep counter, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= NIL;
      back_r      <= NIL;
      free_r      <= '0;
      sweep_r     <= '0;
      sweep_lim_r <= NIL;
      sweep_n_r   <= INIT_N;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_init) begin
        front_r     <= NIL;
        back_r      <= NIL;
        free_r      <= (count_l != '0) ? '0 : NIL;
        sweep_r     <= '0;
        sweep_lim_r <= count_l;
        sweep_n_r   <= count_l;
      end else begin
        if (cmd.front_upd.en) begin
          front_r <= pick(cmd.front_upd.src, idx_r, prev_rd, next_rd, back_r, front_r, free_r);
        end
        if (cmd.back_upd.en) begin
          back_r <= pick(cmd.back_upd.src, idx_r, prev_rd, next_rd, back_r, front_r, free_r);
        end
        if (cmd.free_upd.en) begin
          free_r <= pick(cmd.free_upd.src, idx_r, prev_rd, next_rd, back_r, front_r, free_r);
        end
        if (cmd.sweep) begin
          sweep_r <= sweep_inc;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result fields from the updated pointers
  always_comb begin
    rsp.status     = cmd.out_status;
    case (cmd.out_slot)
      idll_pkg::SS_IDX:    rsp.slot = low8(idx_r);
      idll_pkg::SS_TARGET: rsp.slot = target_r;
      default:             rsp.slot = '0;
    endcase
    rsp.front_slot = (front_r == NIL) ? '0 : low8(front_r);
    rsp.back_slot  = (back_r == NIL) ? '0 : low8(back_r);
    rsp.list_empty = (front_r == NIL);
    rsp.pool_full  = (free_r == NIL);
  end

  // request fields, working slot and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_data.mode;
      target_r <= in_data.target_slot;
    end
    if (cmd.rd_en) begin
      idx_r <= idx_sel;
    end
    if (cmd.out_load) begin
      out_data_r <= rsp;
    end
  end

  // status toward the controller
  assign stat.mode       = mode_r;
  assign stat.free_nil   = (free_r == NIL);
  assign stat.front_nil  = (front_r == NIL);
  assign stat.back_nil   = (back_r == NIL);
  assign stat.p_nil      = (prev_rd == NIL);
  assign stat.q_nil      = (next_rd == NIL);
  assign stat.tgt_oor    = (tgt_ext >= count_c);
  assign stat.sweep_done = (sweep_r == sweep_lim_r);
  assign stat.out_hold   = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hw/rtl/indexed_doubly_linked_list.sv
// top level of the indexed doubly linked list with free chain
`default_nettype none

// Keeps a pool of SLOTS slots as a doubly linked list plus a free chain.
// A request (mode, target_slot) enters on in_valid/in_ready; every request
// gives exactly one result (status, slot, front, back, empty and full flags)
// on out_valid/out_ready. One request is worked at a time: the two link rams
// have one write port each, so a request passes from the idle state through
// the read state and the link write states W1, W2 and W3 or the clear state
// as it needs them to the done state; clear rewrites one slot per cycle.
// in_ready is high only when idle.
// The result sits in an output register; when the receiver stalls the block
// still takes the next request and stops only before loading its result.
// After reset all SLOTS link ram slots are swept, one slot per cycle;
// in_ready stays low during the sweep. The active_slots register
// (byte address 0, reset 256) is written on the apb port and is used by
// clear and by the range check of moves.

module indexed_doubly_linked_list #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  idll_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output idll_pkg::out_rsp_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [0:0] REG_ACTIVE_SLOTS = 1'b0;

  logic [idll_pkg::ACT_W-1:0] act_r;
  idll_pkg::dp_cmd_t          cmd;
  idll_pkg::dp_stat_t         stat;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= idll_pkg::ACT_RESET;
    end else if (psel && penable && pwrite && (paddr[2:2] == REG_ACTIVE_SLOTS)) begin
      act_r <= pwdata[idll_pkg::ACT_W-1:0];
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2:2])
      REG_ACTIVE_SLOTS: prdata = 32'(act_r);
      default:          prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  idll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  idll_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .active_slots (act_r),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  // no link is written while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.prev_wr.en || cmd.next_wr.en || cmd.sweep))
    else $error("link store written while idle");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result loaded over a stalled result");

  // one request at a time
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

endmodule

`default_nettype wire
